// ===== rtl/datetime_string_validator_defines.svh =====
// Assertion macros shared by the datetime string validator RTL.
`ifndef DATETIME_STRING_VALIDATOR_DEFINES_SVH
`define DATETIME_STRING_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is held.
`define DSV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("datetime_string_validator: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while reset is held.
`define DSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("datetime_string_validator: next-cycle check failed");

`endif

// ===== rtl/dsv_pkg.sv =====
// Types, constants and helper functions for the datetime string validator.
package dsv_pkg;

  typedef enum logic [1:0] {
    KIND_TIME     = 2'd0,
    KIND_DATE     = 2'd1,
    KIND_DATETIME = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] SEP_RESET = 8'h20;

  // Character positions within the string.
  localparam logic [4:0] POS_MAX        = 5'd31;
  localparam logic [4:0] TIME_LAST_POS  = 5'd7;
  localparam logic [4:0] DATE_LAST_POS  = 5'd9;
  localparam logic [4:0] SEP_POS        = 5'd10;
  localparam logic [4:0] LONG_TIME_BASE = 5'd11;
  localparam logic [4:0] DT_LAST_POS    = 5'd18;

  // Positions inside an hh:mm:ss field.
  localparam logic [2:0] TQ_COLON_A = 3'd2;
  localparam logic [2:0] TQ_COLON_B = 3'd5;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [6:0] hh;
    logic [6:0] mm;
    logic [6:0] ss;
  } hms_t;

  typedef struct packed {
    logic ok;
    hms_t v;
  } time_upd_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Shift one decimal digit into a two-digit field.
  function automatic logic [6:0] acc10(logic [6:0] v, logic [3:0] d);
    logic [10:0] t;
    t = {4'd0, v} * 11'd10 + {7'd0, d};
    return t[6:0];
  endfunction

  function automatic time_upd_t time_char(logic [2:0] q, logic [7:0] c, hms_t v);
    time_upd_t r;
    logic [7:0] dv;
    r.ok = 1'b1;
    r.v  = v;
    dv   = c - CH_ZERO;
    if (q == TQ_COLON_A || q == TQ_COLON_B) begin
      r.ok = (c == CH_COLON);
    end else if (!is_digit(c)) begin
      r.ok = 1'b0;
    end else begin
      case (q) inside
        3'd0, 3'd1: r.v.hh = acc10(v.hh, dv[3:0]);
        3'd3, 3'd4: r.v.mm = acc10(v.mm, dv[3:0]);
        default:    r.v.ss = acc10(v.ss, dv[3:0]);
      endcase
    end
    return r;
  endfunction

  function automatic logic time_ok(hms_t v);
    return (v.hh < 7'd24) && (v.mm < 7'd60) && (v.ss < 7'd60);
  endfunction

  // Year is kept as century (first two digits) and year-of-century.
  // Leap: year-of-century nonzero and divisible by 4, or year-of-century
  // zero and century divisible by 4 (100 is a multiple of 4).
  function automatic logic date_ok(logic [6:0] century, logic [6:0] yy,
                                   logic [6:0] mo, logic [6:0] dy);
    logic       leap;
    logic [3:0] midx;
    logic [4:0] mlen;
    leap = (yy == 7'd0) ? (century[1:0] == 2'd0) : (yy[1:0] == 2'd0);
    midx = mo[3:0] - 4'd1;
    mlen = MONTH_LEN[midx];
    if (mo < 7'd1 || mo > 7'd12 || dy < 7'd1 || dy > 7'd31) begin
      return 1'b0;
    end
    return (dy <= {2'd0, mlen}) || (mo == 7'd2 && leap && dy == 7'd29);
  endfunction

endpackage

// ===== rtl/datetime_string_validator.sv =====
// Top level of the datetime string validator: streaming character checker.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in_     | input     | in_valid / in_stall  | in_ch[7:0], in_last_char
//   out_    | output    | out_valid / out_stall| out_valid_res, out_kind[1:0]
//   cfg_    | input     | cfg_wr_en            | cfg_wr_data[7:0] (separator)
//
// One character transfers per cycle, back to back, unless the input stalls,
// and is held in the input register; from there it advances the string
// state, and a final character loads its verdict into the output register.
// Reset (rst_n low, synchronous) empties both registers, clears the string
// state and sets the separator to a space.
// Only a final character held behind a stalled verdict stalls the input.
module datetime_string_validator
  import dsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_valid_res,
  output logic [1:0] out_kind,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  // Input register.
  logic       a_vld_r;
  logic [7:0] a_ch_r;
  logic       a_last_r;

  // String state.
  logic [4:0] pos_r,     pos_nxt;
  logic       t_ok_r,    t_ok_nxt;
  logic       d_ok_r,    d_ok_nxt;
  logic [6:0] cent_r,    cent_nxt;
  logic [6:0] yy_r,      yy_nxt;
  logic [6:0] mo_r,      mo_nxt;
  logic [6:0] dy_r,      dy_nxt;
  hms_t       st_r,      st_nxt;
  hms_t       lt_r,      lt_nxt;

  logic [7:0] sep_r;

  // Output register.
  logic       out_vld_r;
  logic       res_r,     res_nxt;
  kind_t      kind_r,    kind_nxt;

  logic       a_move;
  logic       a_fire;
  logic       in_fire;
  logic       out_free;

  time_upd_t  st_upd;
  time_upd_t  lt_upd;
  logic [4:0] lq;
  logic [7:0] dv;
  logic       date_ch_ok;

  // The output register frees when empty or being taken this cycle.
  assign out_free = !out_vld_r || !out_stall;
  // A final character may only advance when the output register frees.
  assign a_move   = !a_last_r || out_free;
  assign a_fire   = a_vld_r && a_move;
  assign in_stall = a_vld_r && !a_move;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid     = out_vld_r;
  assign out_valid_res = res_r;
  assign out_kind      = kind_r;

  always_comb begin
    lq     = pos_r - LONG_TIME_BASE;
    dv     = a_ch_r - CH_ZERO;
    st_upd = time_char(pos_r[2:0], a_ch_r, st_r);
    lt_upd = time_char(lq[2:0], a_ch_r, lt_r);

    pos_nxt  = (pos_r < POS_MAX) ? pos_r + 5'd1 : pos_r;
    t_ok_nxt = t_ok_r;
    d_ok_nxt = d_ok_r;
    cent_nxt = cent_r;
    yy_nxt   = yy_r;
    mo_nxt   = mo_r;
    dy_nxt   = dy_r;
    st_nxt   = st_r;
    lt_nxt   = lt_r;

    // Short time layout covers positions 0..7.
    if (pos_r <= TIME_LAST_POS) begin
      st_nxt = st_upd.v;
      if (!st_upd.ok) begin
        t_ok_nxt = 1'b0;
      end
    end

    // Date layout, separator, then long time.
    date_ch_ok = 1'b1;
    if (pos_r <= DATE_LAST_POS) begin
      if (pos_r == 5'd4 || pos_r == 5'd7) begin
        date_ch_ok = (a_ch_r == CH_DASH);
      end else if (!is_digit(a_ch_r)) begin
        date_ch_ok = 1'b0;
      end else begin
        case (pos_r) inside
          5'd0, 5'd1: cent_nxt = acc10(cent_r, dv[3:0]);
          5'd2, 5'd3: yy_nxt   = acc10(yy_r, dv[3:0]);
          5'd5, 5'd6: mo_nxt   = acc10(mo_r, dv[3:0]);
          default:    dy_nxt   = acc10(dy_r, dv[3:0]);
        endcase
      end
    end else if (pos_r == SEP_POS) begin
      date_ch_ok = (a_ch_r == sep_r);
    end else if (pos_r <= DT_LAST_POS) begin
      lt_nxt     = lt_upd.v;
      date_ch_ok = lt_upd.ok;
    end
    if (!date_ch_ok) begin
      d_ok_nxt = 1'b0;
    end

    // Verdict for a final character, from the state after this character.
    case (pos_r)
      TIME_LAST_POS: begin
        kind_nxt = KIND_TIME;
        res_nxt  = t_ok_nxt && time_ok(st_nxt);
      end
      DATE_LAST_POS: begin
        kind_nxt = KIND_DATE;
        res_nxt  = d_ok_nxt && date_ok(cent_nxt, yy_nxt, mo_nxt, dy_nxt);
      end
      DT_LAST_POS: begin
        kind_nxt = KIND_DATETIME;
        res_nxt  = d_ok_nxt && date_ok(cent_nxt, yy_nxt, mo_nxt, dy_nxt)
                   && time_ok(lt_nxt);
      end
      default: begin
        kind_nxt = KIND_NONE;
        res_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      sep_r     <= SEP_RESET;
      pos_r     <= '0;
      t_ok_r    <= 1'b1;
      d_ok_r    <= 1'b1;
      cent_r    <= '0;
      yy_r      <= '0;
      mo_r      <= '0;
      dy_r      <= '0;
      st_r      <= '0;
      lt_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        sep_r <= cfg_wr_data;
      end

      // Input register: load on transfer, drop when the held item advances.
      if (in_fire) begin
        a_vld_r <= 1'b1;
      end else if (a_fire) begin
        a_vld_r <= 1'b0;
      end

      // Output register: drop on transfer, load on a final character.
      if (a_fire && a_last_r) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end

      if (a_fire) begin
        if (a_last_r) begin
          // Clear the string state for the next string.
          pos_r  <= '0;
          t_ok_r <= 1'b1;
          d_ok_r <= 1'b1;
          cent_r <= '0;
          yy_r   <= '0;
          mo_r   <= '0;
          dy_r   <= '0;
          st_r   <= '0;
          lt_r   <= '0;
        end else begin
          pos_r  <= pos_nxt;
          t_ok_r <= t_ok_nxt;
          d_ok_r <= d_ok_nxt;
          cent_r <= cent_nxt;
          yy_r   <= yy_nxt;
          mo_r   <= mo_nxt;
          dy_r   <= dy_nxt;
          st_r   <= st_nxt;
          lt_r   <= lt_nxt;
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_ch_r   <= in_ch;
      a_last_r <= in_last_char;
    end
    if (a_fire && a_last_r) begin
      res_r  <= res_nxt;
      kind_r <= kind_nxt;
    end
  end

`include "datetime_string_validator_defines.svh"

  `DSV_ASSERT_SAME(a_none_invalid, out_vld_r && kind_r == KIND_NONE, !res_r)
  `DSV_ASSERT_NEXT(a_clear_after_last, a_fire && a_last_r, pos_r == 5'd0 && t_ok_r && d_ok_r)
  `DSV_ASSERT_NEXT(a_pos_saturates, a_fire && !a_last_r && pos_r == POS_MAX, pos_r == POS_MAX)
  `DSV_ASSERT_SAME(a_stall_only_last, in_stall, a_vld_r && a_last_r && out_vld_r)

endmodule

// ===== bench/datetime_verdict_checker.sv =====
`timescale 1ns / 100ps
// Checker for the datetime string validator: predicts each string's verdict and compares.
module datetime_verdict_checker
  import dsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_last_char,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_valid_res,
  input  logic [1:0] out_kind,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output int         mismatches,
  output int         strings_open
);

  typedef struct packed {
    logic  ok;
    kind_t kind;
  } verdict_t;

  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic [7:0]      sep_char;
  logic [4:0]      char_pos;
  logic            time_fmt_ok;
  logic            date_fmt_ok;
  logic [13:0]     year;
  logic [7:0]      month;
  logic [7:0]      day;
  logic [2:0][7:0] hms_short;
  logic [2:0][7:0] hms_long;
  verdict_t        verdicts_due [$];

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: verdict mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic clear_string();
    char_pos    = '0;
    time_fmt_ok = 1'b1;
    date_fmt_ok = 1'b1;
    year        = '0;
    month       = '0;
    day         = '0;
    hms_short   = '0;
    hms_long    = '0;
  endtask

  // One character of an hh:mm:ss field at offset q; digits shift into hms.
  function automatic logic clock_digit(input int q, input logic [7:0] c,
                                       inout logic [2:0][7:0] hms);
    if (q == 2 || q == 5) return c == CH_COLON;
    if (c < CH_ZERO || c > CH_NINE) return 1'b0;
    hms[q / 3] = 8'(hms[q / 3] * 10 + (int'(c) - int'(CH_ZERO)));
    return 1'b1;
  endfunction

  function automatic logic clock_ok(input logic [2:0][7:0] hms);
    return hms[0] < 24 && hms[1] < 60 && hms[2] < 60;
  endfunction

  function automatic logic calendar_ok();
    int   y;
    int   m;
    int   d;
    logic leap;
    y = year;
    m = month;
    d = day;
    if (m < 1 || m > 12 || d < 1 || d > 31) return 1'b0;
    if (d <= MONTH_DAYS[m - 1]) return 1'b1;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    return m == 2 && leap && d == 29;
  endfunction

  // Advance the string state by one character; queue a verdict on the last.
  task automatic scan_char(input logic [7:0] c, input logic last);
    int       p;
    int       dig;
    verdict_t v;
    p   = char_pos;
    dig = int'(c) - int'(CH_ZERO);
    if (p < 8 && !clock_digit(p, c, hms_short)) time_fmt_ok = 1'b0;
    if (p < 10) begin
      if (p == 4 || p == 7) begin
        if (c != CH_DASH) date_fmt_ok = 1'b0;
      end else if (c < CH_ZERO || c > CH_NINE) begin
        date_fmt_ok = 1'b0;
      end else if (p < 4) begin
        year = 14'(year * 10 + dig);
      end else if (p < 7) begin
        month = 8'(month * 10 + dig);
      end else begin
        day = 8'(day * 10 + dig);
      end
    end else if (p == 10) begin
      if (c != sep_char) date_fmt_ok = 1'b0;
    end else if (p < 19) begin
      if (!clock_digit(p - 11, c, hms_long)) date_fmt_ok = 1'b0;
    end
    if (char_pos != POS_MAX) char_pos = char_pos + 5'd1;
    if (last) begin
      v.ok   = 1'b0;
      v.kind = KIND_NONE;
      case (p + 1)
        8: begin
          v.kind = KIND_TIME;
          v.ok   = time_fmt_ok && clock_ok(hms_short);
        end
        10: begin
          v.kind = KIND_DATE;
          v.ok   = date_fmt_ok && calendar_ok();
        end
        19: begin
          v.kind = KIND_DATETIME;
          v.ok   = date_fmt_ok && calendar_ok() && clock_ok(hms_long);
        end
        default: ;
      endcase
      verdicts_due.push_back(v);
      clear_string();
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      sep_char = SEP_RESET;
      clear_string();
      verdicts_due.delete();
    end else begin
      if (cfg_wr_en) sep_char = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch("result with no string pending", out_kind, -1);
        end else begin
          want = verdicts_due.pop_front();
          if (out_valid_res !== want.ok) flag_mismatch("valid_res", out_valid_res, want.ok);
          if (out_kind !== want.kind) flag_mismatch("kind", out_kind, want.kind);
        end
      end
      if (in_valid && !in_stall) scan_char(in_ch, in_last_char);
    end
    strings_open = verdicts_due.size();
  end

endmodule

// ===== bench/tb_datetime_string_validator.sv =====
`timescale 1ns / 100ps
// Testbench top: feeds date/time strings to the validator and gives the verdict.
module tb_datetime_string_validator;
  import dsv_pkg::*;

  typedef logic [7:0] text_t [$];

  // Cycles without any transfer before the run is declared hung; well above
  // the long receiver hold-off plus the worst gaps on both sides.
  localparam int IDLE_LIMIT    = 4000;
  localparam int LONG_HOLD     = 300;
  // The block holds a character in its input register before it reaches the
  // string state; give margin.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_CHARS  = 370;
  localparam int PHASES        = 6;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_ch;
  logic       in_last_char;
  logic       out_valid;
  logic       out_stall;
  logic       out_valid_res;
  logic [1:0] out_kind;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  int         mismatches;
  int         strings_open;
  int         chars_sent;
  int         idle_cycles;
  bit         steady;     // both sides run without idling while set
  bit         hold_req;   // ask the receiver for one long hold-off
  logic [7:0] sep_now;    // separator currently programmed

  datetime_string_validator i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ch        (in_ch),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_valid_res(out_valid_res),
    .out_kind     (out_kind),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  datetime_verdict_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hang detection: count cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: draw a stall for every result, then wait for its transfer.
  // A pending hold request turns the next stall into a long hold-off so the
  // block fills up and pushes back on its input.
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        n        = LONG_HOLD;
        hold_req = 1'b0;
      end else if (steady) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 4);
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic void add_text(inout text_t t, input string s);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endfunction

  // Offer one character after a random gap; hold it until its transfer.
  // Valid stays high on return so a back-to-back character needs no toggle.
  task automatic put_char(input logic [7:0] c, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_ch        <= c;
    in_last_char <= last;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_bytes(input text_t t);
    foreach (t[i]) put_char(t[i], i == t.size() - 1);
  endtask

  task automatic send_text(input string s);
    text_t t;
    add_text(t, s);
    send_bytes(t);
  endtask

  // Drop valid and wait until every string has its verdict, then let any
  // character still inside the block drain out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (strings_open != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only call with the block drained.
  task automatic write_sep(input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sep_now = v;
  endtask

  // Build a time, date or date-time string: fields mostly in range, with
  // out-of-range values, leap-day probes and odd separators mixed in.
  function automatic text_t make_stamp(input kind_t form);
    text_t t;
    int    y;
    int    mo;
    int    d;
    int    h;
    int    mi;
    int    s;
    case ($urandom_range(0, 3))
      0:       y = $urandom_range(0, 9999);
      1:       y = 100 * $urandom_range(0, 99);
      2:       y = 4 * $urandom_range(0, 2499);
      default: y = $urandom_range(1890, 2110);
    endcase
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    d  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
    if ($urandom_range(0, 7) == 0) begin
      mo = 2;
      d  = $urandom_range(28, 30);
    end
    h  = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 99) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
    s  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
    if (form != KIND_TIME) add_text(t, $sformatf("%04d-%02d-%02d", y, mo, d));
    if (form == KIND_DATETIME) begin
      t.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : sep_now);
    end
    if (form != KIND_DATE) add_text(t, $sformatf("%02d:%02d:%02d", h, mi, s));
    return t;
  endfunction

  // Mostly well-formed stamps with random content; the rest is damaged
  // stamps (one byte hit, one short, one long) and raw byte noise.
  task automatic send_random_string();
    text_t t;
    int    pick;
    int    n;
    pick = $urandom_range(0, 15);
    if (pick < 6) begin
      t = make_stamp(KIND_DATETIME);
    end else if (pick < 9) begin
      t = make_stamp(KIND_DATE);
    end else if (pick < 12) begin
      t = make_stamp(KIND_TIME);
    end else begin
      n = $urandom_range(1, 40);
      repeat (n) t.push_back(8'($urandom_range(0, 255)));
    end
    if (pick < 12) begin
      case ($urandom_range(0, 7))
        0:       t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
        1:       void'(t.pop_back());
        2:       t.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
    end
    send_bytes(t);
  endtask

  initial begin
    text_t      t;
    logic [7:0] phase_seps [PHASES];

    in_valid     = 1'b0;
    in_ch        = '0;
    in_last_char = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    rst_n        = 1'b0;
    sep_now      = SEP_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed strings with the separator still at its reset value.
    // Time bounds: both extremes valid, then each field one past its range.
    send_text("00:00:00");
    send_text("23:59:59");
    send_text("24:00:00");
    send_text("09:60:00");
    send_text("09:00:60");
    // Leap days: year zero, a plain century, a 400-year century, a common year.
    send_text("0000-02-29");
    send_text("1900-02-29");
    send_text("2000-02-29");
    send_text("2023-02-29");
    send_text("9999-12-31");
    send_text("2023-04-31");
    send_text("2023-13-01");
    send_text("2023-00-10");
    send_text("2023-01-00");
    send_text("2024-02-29 23:59:59");
    send_text("2024-02-29T23:59:59");
    // Layout breaks: wrong literal and a letter where a digit belongs.
    send_text("12-34:56");
    send_text("1a:34:56");
    // A zero byte is an ordinary character: it lengthens the string.
    add_text(t, "12:34:56");
    t.insert(3, 8'h00);
    send_bytes(t);
    put_char(8'h00, 1'b1);
    // Odd lengths, and a long string that runs the position count into its
    // saturation.
    send_text("7");
    send_text("12:34:567");
    send_text("1234567890123456789012345678901234567890");

    // A letter and a digit as separator are compared literally.
    wait_drained();
    write_sep("T");
    send_text("1999-12-31T00:00:00");
    send_text("1999-12-31 00:00:00");
    wait_drained();
    write_sep("5");
    send_text("2000-01-01512:00:00");

    // Back-pressure: hold the result side off for a long stretch while
    // characters keep coming, then pause until every verdict is back.
    steady   = 1'b1;
    hold_req = 1'b1;
    repeat (16) send_bytes(make_stamp(KIND_TIME));
    steady = 1'b0;
    wait_drained();

    // Random phases, each under its own separator, the extremes included.
    phase_seps = '{8'h00, 8'hFF, "T", 8'($urandom_range(0, 255)), "5", SEP_RESET};
    chars_sent = 0;
    for (int i = 0; i < PHASES; i++) begin
      wait_drained();
      write_sep(phase_seps[i]);
      steady = (i == 2) || ($urandom_range(0, 3) == 0);
      while (chars_sent < (i + 1) * RANDOM_CHARS / PHASES) send_random_string();
    end
    steady = 1'b0;

    wait_drained();
    if (mismatches == 0 && strings_open == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
